>>> hw/rtl/tpp_pkg.sv
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Internal widths, all derived from the word and fraction widths.
    localparam int SQ_W  = 2 * WORD_BITS;                 // speed squared
    localparam int CN_W  = 2 * WORD_BITS + 2;             // distance dividend magnitude
    localparam int CS_W  = CN_W + 1;                      // signed distance dividend
    localparam int CD_W  = WORD_BITS + 2;                 // 2*A, 2*D, 2*(A+D)
    localparam int PP_W  = 2 * WORD_BITS + 1;             // 2*A times one half of d1
    localparam int PR_W  = 3 * WORD_BITS + 2;             // 2*A*d1 magnitude
    localparam int SW    = 3 * WORD_BITS + 4;             // signed wide work value
    localparam int RB    = (3 * WORD_BITS + 3) / 2;       // root bits
    localparam int SQW   = 2 * RB;                        // radicand bits
    localparam int DC_W  = 2 * WORD_BITS + 1;             // cruise distance
    localparam int FN_W  = 2 * WORD_BITS + FRAC_BITS + 1; // time dividend
    localparam int MG_W  = WORD_BITS + 1;                 // speed difference magnitude

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MIN_LEN_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd2;

    localparam logic [WORD_BITS-1:0] ACCEL_RST   = 32'd32768000;
    localparam logic [WORD_BITS-1:0] DECEL_RST   = 32'd32768000;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 16'd1;

    typedef struct packed {
        logic [WORD_BITS-1:0] seg_length;
        logic [WORD_BITS-1:0] start_speed;
        logic [WORD_BITS-1:0] end_speed;
        logic [WORD_BITS-1:0] speed_cap;
    } seg_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] ramp_up_time;
        logic signed [WORD_BITS-1:0] cruise_time;
        logic signed [WORD_BITS-1:0] ramp_down_time;
        logic        [WORD_BITS-1:0] peak_speed;
        logic                        is_triangle;
        logic                        is_degenerate;
    } prof_t;

endpackage

>>> hw/rtl/tpp_div.sv
`timescale 1ns / 1ps

module tpp_div #(
    parameter int NB = 8,
    parameter int DB = 8,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          v,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    input  logic [TW-1:0] tag,
    output logic          q_valid,
    output logic [NB-1:0] quo,
    output logic [TW-1:0] q_tag
);

    localparam int CW = DB + 1;
    localparam int XW = DB + 2;

    // Each stage settles one quotient bit, most significant first. The dividend
    // shifts out of the top of nq while quotient bits shift in at the bottom.
    logic [NB-1:0] nq_reg  [NB];
    logic [DB-1:0] rem_reg [NB];
    logic [DB-1:0] den_reg [NB];
    logic [TW-1:0] tag_reg [NB];
    logic          v_reg   [NB];

    for (genvar k = 0; k < NB; k++)
    begin : g_st
        logic [NB-1:0] nq_in;
        logic [DB-1:0] rem_in;
        logic [DB-1:0] den_in;
        logic [TW-1:0] tag_in;
        logic          v_in;
        logic [CW-1:0] cand;
        logic [XW-1:0] diff;
        logic          fit;

        if (k == 0)
        begin : g_first
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
            assign tag_in = tag;
            assign v_in   = v;
        end
        else
        begin : g_next
            assign nq_in  = nq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        assign cand = {rem_in, nq_in[NB-1]};
        assign diff = XW'(cand) - XW'(den_in);
        assign fit  = ~diff[XW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]  <= {nq_in[NB-2:0], fit};
                rem_reg[k] <= fit ? diff[DB-1:0] : cand[DB-1:0];
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign q_valid = v_reg[NB-1];
    assign quo     = nq_reg[NB-1];
    assign q_tag   = tag_reg[NB-1];

endmodule

>>> hw/rtl/trapezoid_profile_planner_unit.sv
`timescale 1ns / 1ps

// Trapezoidal velocity profile planner.
// The seg channel takes one motion segment per beat: length, entry speed,
// exit speed and cap speed, all unsigned Q16.16. The prof channel returns one
// profile per segment, in order: ramp-up, cruise and ramp-down times, the
// peak speed reached and the triangle and degenerate flags.
// The cfg channel writes the acceleration rate, deceleration rate and minimum
// length by index; it is always ready and should only be used while no
// segment is in flight.
// Throughput is one segment per cycle while seg_ready is high. An accepted
// segment passes ten plain register stages plus three bit-per-stage units
// in series: the distance dividers (66 stages), the peak speed square root
// (49 stages) and the time dividers (81 stages).
// Reset restores the default rates and minimum length and empties the
// pipeline; segments in flight are dropped and none is invented across it.
// When the receiver stalls, one finished profile waits in the output register
// and one more in a skid register; then the whole pipeline holds in place and
// seg_ready drops until the skid register drains.
module trapezoid_profile_planner_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                seg_valid,
    output logic                                seg_ready,
    input  tpp_pkg::seg_t                       seg,
    output logic                                prof_valid,
    input  logic                                prof_ready,
    output tpp_pkg::prof_t                      prof,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import tpp_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int RM_W = RB + 2;
    localparam int TR_W = RB + 4;

    typedef struct packed {
        logic [W-1:0]    len;
        logic [W-1:0]    ve;
        logic [W-1:0]    vx;
        logic [W-1:0]    vm;
        logic [SQ_W-1:0] ve2;
        logic            deg;
    } c_tag_t;

    typedef struct packed {
        logic [W-1:0]    ve;
        logic [W-1:0]    vx;
        logic [W-1:0]    vm;
        logic [DC_W-1:0] dc;
        logic            is_tri;
        logic            deg;
    } s_tag_t;

    typedef struct packed {
        logic [W-1:0] vp;
        logic         is_tri;
        logic         deg;
    } f_tag_t;

    localparam int CT_W = $bits(c_tag_t) + 1;
    localparam int FT_W = $bits(f_tag_t) + 1;

    function automatic logic [W-1:0] sat_time(input logic [FN_W-1:0] q, input logic neg);
        logic [FN_W-1:0] max_pos;
        logic [FN_W-1:0] max_neg;
        logic [W-1:0]    r;
        max_pos = FN_W'({1'b0, {(W-1){1'b1}}});
        max_neg = FN_W'(1) << (W - 1);
        if (!neg)
        begin
            r = (q > max_pos) ? max_pos[W-1:0] : q[W-1:0];
        end
        else
        begin
            r = (q > max_neg) ? max_neg[W-1:0] : (W'(0) - q[W-1:0]);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- config
    logic [W-1:0]         accel_reg;
    logic [W-1:0]         decel_reg;
    logic [MIN_LEN_W-1:0] min_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg   <= ACCEL_RST;
            decel_reg   <= DECEL_RST;
            min_len_reg <= MIN_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ACCEL:   accel_reg   <= cfg_data[W-1:0];
                CFG_DECEL:   decel_reg   <= cfg_data[W-1:0];
                CFG_MIN_LEN: min_len_reg <= cfg_data[MIN_LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    // A rate of zero behaves as the smallest rate.
    logic [W-1:0]    a_eff;
    logic [W-1:0]    d_eff;
    logic [W:0]      a2;
    logic [W:0]      d2;
    logic [CD_W-1:0] ad2;

    assign a_eff = (accel_reg == '0) ? W'(1) : accel_reg;
    assign d_eff = (decel_reg == '0) ? W'(1) : decel_reg;
    assign a2    = {a_eff, 1'b0};
    assign d2    = {d_eff, 1'b0};
    assign ad2   = {(CD_W - 1)'(a_eff) + (CD_W - 1)'(d_eff), 1'b0};

    // ------------------------------------------------------------- handshake
    logic adv;
    logic skid_valid_reg;
    logic prof_valid_reg;

    assign adv       = ~skid_valid_reg;
    assign seg_ready = adv;

    // ---------------------------------------------------- front stages 0..3
    logic            v0_reg, v1_reg, v2_reg, v3_reg;
    logic [W-1:0]    len0_reg, ve0_reg, vx0_reg, vm0_reg;
    logic            deg0_reg;
    c_tag_t          ct1_reg, ct2_reg, ct3_reg;
    logic [SQ_W-1:0] vx2_1_reg, vm2_1_reg, dl1_reg;
    logic [CS_W-1:0] na2_reg, nd2_reg, n12_reg;
    logic [CN_W-1:0] ma3_reg, md3_reg, m13_reg;
    logic            sa3_reg, sd3_reg, s13_reg;

    // ------------------------------------------------- distance dividers
    logic            vca, vcd, vc1;
    logic [CN_W-1:0] qa, qd, q1;
    logic [CT_W-1:0] tca;
    logic            tcd, tc1;
    c_tag_t          ctc;
    logic            sac;

    assign {ctc, sac} = tca;

    tpp_div #(.NB(CN_W), .DB(CD_W), .TW(CT_W)) u_div_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v3_reg),
        .num     (ma3_reg),
        .den     (CD_W'(a2)),
        .tag     ({ct3_reg, sa3_reg}),
        .q_valid (vca),
        .quo     (qa),
        .q_tag   (tca)
    );

    tpp_div #(.NB(CN_W), .DB(CD_W), .TW(1)) u_div_d (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v3_reg),
        .num     (md3_reg),
        .den     (CD_W'(d2)),
        .tag     (sd3_reg),
        .q_valid (vcd),
        .quo     (qd),
        .q_tag   (tcd)
    );

    tpp_div #(.NB(CN_W), .DB(CD_W), .TW(1)) u_div_1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v3_reg),
        .num     (m13_reg),
        .den     (ad2),
        .tag     (s13_reg),
        .q_valid (vc1),
        .quo     (q1),
        .q_tag   (tc1)
    );

    // ---------------------------------------------------- mid stages 4..6
    logic            v4_reg, v5_reg, v6_reg;
    c_tag_t          ct4_reg, ct5_reg;
    logic [SW-1:0]   da4_reg, dd4_reg;
    logic [PP_W-1:0] plo4_reg, phi4_reg;
    logic            s14_reg, s15_reg;
    logic [SW-1:0]   dc5_reg;
    logic [PR_W-1:0] prod5_reg;
    logic [SW-1:0]   vp2_6_reg;
    s_tag_t          st6_reg;

    // ------------------------------------------------------------ registers
    logic            v7_reg, v8_reg;
    s_tag_t          st7_reg;
    logic [W-1:0]    vp7_reg;
    logic [W:0]      du8_reg, dv8_reg;
    logic [FN_W-1:0] tcn8_reg;
    logic [W-1:0]    vm8_reg;
    logic            tcsp8_reg, tcnz8_reg;
    f_tag_t          ft8_reg;

    // ------------------------------------------------------------ sqrt unit
    logic [SQW-1:0] sq_rad_reg  [RB];
    logic [RB-1:0]  sq_root_reg [RB];
    logic [RM_W-1:0] sq_rem_reg [RB];
    s_tag_t         sq_tag_reg  [RB];
    logic           sq_v_reg    [RB];
    logic [SQW-1:0] rad0;

    // Only a triangle with a non-negative squared peak needs the root.
    assign rad0 = (st6_reg.is_tri && !vp2_6_reg[SW-1]) ? vp2_6_reg[SQW-1:0] : '0;

    for (genvar k = 0; k < RB; k++)
    begin : g_sq
        logic [SQW-1:0]  rad_in;
        logic [RB-1:0]   root_in;
        logic [RM_W-1:0] rem_in;
        s_tag_t          tag_in;
        logic            v_in;
        logic [TR_W-1:0] cand;
        logic [TR_W-1:0] trial;
        logic            fit;

        if (k == 0)
        begin : g_first
            assign rad_in  = rad0;
            assign root_in = '0;
            assign rem_in  = '0;
            assign tag_in  = st6_reg;
            assign v_in    = v6_reg;
        end
        else
        begin : g_next
            assign rad_in  = sq_rad_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign tag_in  = sq_tag_reg[k-1];
            assign v_in    = sq_v_reg[k-1];
        end

        assign cand  = {rem_in, rad_in[SQW-1:SQW-2]};
        assign trial = TR_W'({root_in, 2'b01});
        assign fit   = (cand >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[k]  <= rad_in << 2;
                sq_root_reg[k] <= {root_in[RB-2:0], fit};
                sq_rem_reg[k]  <= fit ? RM_W'(cand - trial) : RM_W'(cand);
                sq_tag_reg[k]  <= tag_in;
            end
        end
    end

    logic [RB-1:0] root;
    s_tag_t        sqt;
    logic          vs;

    assign root = sq_root_reg[RB-1];
    assign sqt  = sq_tag_reg[RB-1];
    assign vs   = sq_v_reg[RB-1];

    // ------------------------------------------------------- time dividers
    logic [MG_W-1:0] mu, mv;
    logic [FN_W-1:0] nu, nv;

    assign mu = du8_reg[W] ? MG_W'(-du8_reg) : MG_W'(du8_reg);
    assign mv = dv8_reg[W] ? MG_W'(-dv8_reg) : MG_W'(dv8_reg);
    assign nu = FN_W'({mu, {F{1'b0}}});
    assign nv = FN_W'({mv, {F{1'b0}}});

    logic            vfu, vfd, vfc;
    logic [FN_W-1:0] qu, qdn, qc;
    logic [FT_W-1:0] tfu;
    logic            tfd;
    logic [1:0]      tfc;
    f_tag_t          ftf;
    logic            suf;

    assign {ftf, suf} = tfu;

    tpp_div #(.NB(FN_W), .DB(W), .TW(FT_W)) u_div_u (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v8_reg),
        .num     (nu),
        .den     (a_eff),
        .tag     ({ft8_reg, du8_reg[W]}),
        .q_valid (vfu),
        .quo     (qu),
        .q_tag   (tfu)
    );

    tpp_div #(.NB(FN_W), .DB(W), .TW(1)) u_div_w (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v8_reg),
        .num     (nv),
        .den     (d_eff),
        .tag     (dv8_reg[W]),
        .q_valid (vfd),
        .quo     (qdn),
        .q_tag   (tfd)
    );

    tpp_div #(.NB(FN_W), .DB(W), .TW(2)) u_div_c (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .v       (v8_reg),
        .num     (tcn8_reg),
        .den     (vm8_reg),
        .tag     ({tcsp8_reg, tcnz8_reg}),
        .q_valid (vfc),
        .quo     (qc),
        .q_tag   (tfc)
    );

    // ----------------------------------------------------- pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= seg_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= vca & vcd & vc1;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= vs;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 0: capture the segment and flag short ones.
            len0_reg <= seg.seg_length;
            ve0_reg  <= seg.start_speed;
            vx0_reg  <= seg.end_speed;
            vm0_reg  <= seg.speed_cap;
            deg0_reg <= (seg.seg_length < W'(min_len_reg));

            // Stage 1: squares and D*L.
            ct1_reg.len <= len0_reg;
            ct1_reg.ve  <= ve0_reg;
            ct1_reg.vx  <= vx0_reg;
            ct1_reg.vm  <= vm0_reg;
            ct1_reg.ve2 <= SQ_W'(ve0_reg) * SQ_W'(ve0_reg);
            ct1_reg.deg <= deg0_reg;
            vx2_1_reg   <= SQ_W'(vx0_reg) * SQ_W'(vx0_reg);
            vm2_1_reg   <= SQ_W'(vm0_reg) * SQ_W'(vm0_reg);
            dl1_reg     <= SQ_W'(d_eff) * SQ_W'(len0_reg);

            // Stage 2: signed numerators of the ramp and crossover distances.
            ct2_reg <= ct1_reg;
            na2_reg <= CS_W'(vm2_1_reg) - CS_W'(ct1_reg.ve2);
            nd2_reg <= CS_W'(vm2_1_reg) - CS_W'(vx2_1_reg);
            n12_reg <= CS_W'(vx2_1_reg) - CS_W'(ct1_reg.ve2) + CS_W'({dl1_reg, 1'b0});

            // Stage 3: sign and magnitude for the dividers.
            ct3_reg <= ct2_reg;
            sa3_reg <= na2_reg[CS_W-1];
            sd3_reg <= nd2_reg[CS_W-1];
            s13_reg <= n12_reg[CS_W-1];
            ma3_reg <= na2_reg[CS_W-1] ? CN_W'(-na2_reg) : CN_W'(na2_reg);
            md3_reg <= nd2_reg[CS_W-1] ? CN_W'(-nd2_reg) : CN_W'(nd2_reg);
            m13_reg <= n12_reg[CS_W-1] ? CN_W'(-n12_reg) : CN_W'(n12_reg);

            // Stage 4: signed ramp distances; 2*A*d1 in two partial products.
            ct4_reg  <= ctc;
            da4_reg  <= sac ? (SW'(0) - SW'(qa)) : SW'(qa);
            dd4_reg  <= tcd ? (SW'(0) - SW'(qd)) : SW'(qd);
            plo4_reg <= PP_W'(a2) * PP_W'(q1[W-1:0]);
            phi4_reg <= PP_W'(a2) * PP_W'(q1[2*W-1:W]);
            s14_reg  <= tc1;

            // Stage 5: leftover distance; it is negative exactly for a triangle.
            ct5_reg   <= ct4_reg;
            dc5_reg   <= SW'(ct4_reg.len) - da4_reg - dd4_reg;
            prod5_reg <= PR_W'(plo4_reg) + PR_W'({phi4_reg, {W{1'b0}}});
            s15_reg   <= s14_reg;

            // Stage 6: squared triangle peak.
            vp2_6_reg      <= s15_reg ? (SW'(ct5_reg.ve2) - SW'(prod5_reg))
                                      : (SW'(ct5_reg.ve2) + SW'(prod5_reg));
            st6_reg.ve     <= ct5_reg.ve;
            st6_reg.vx     <= ct5_reg.vx;
            st6_reg.vm     <= ct5_reg.vm;
            st6_reg.dc     <= dc5_reg[DC_W-1:0];
            st6_reg.is_tri <= dc5_reg[SW-1];
            st6_reg.deg    <= ct5_reg.deg;

            // Stage 7: peak speed, saturated to the word.
            st7_reg <= sqt;
            if (sqt.is_tri)
            begin
                vp7_reg <= (|root[RB-1:W]) ? '1 : root[W-1:0];
            end
            else
            begin
                vp7_reg <= sqt.vm;
            end

            // Stage 8: time dividends.
            du8_reg        <= {1'b0, vp7_reg} - {1'b0, st7_reg.ve};
            dv8_reg        <= {1'b0, vp7_reg} - {1'b0, st7_reg.vx};
            tcn8_reg       <= st7_reg.is_tri ? '0 : FN_W'({st7_reg.dc, {F{1'b0}}});
            vm8_reg        <= st7_reg.vm;
            tcsp8_reg      <= (st7_reg.vm == '0);
            tcnz8_reg      <= !st7_reg.is_tri && (st7_reg.dc != '0);
            ft8_reg.vp     <= vp7_reg;
            ft8_reg.is_tri <= st7_reg.is_tri;
            ft8_reg.deg    <= st7_reg.deg;
        end
    end

    // --------------------------------------------------------------- result
    prof_t result;
    prof_t prof_reg;
    prof_t skid_reg;
    logic  fin_valid;
    logic  take;
    logic  hold;

    always_comb
    begin
        result = '0;
        if (ftf.deg)
        begin
            result.is_degenerate = 1'b1;
        end
        else
        begin
            result.ramp_up_time   = sat_time(qu, suf);
            result.ramp_down_time = sat_time(qdn, tfd);
            // A zero cap speed saturates the cruise time unless nothing is left.
            if (tfc[1])
            begin
                result.cruise_time = tfc[0] ? {1'b0, {(W-1){1'b1}}} : '0;
            end
            else
            begin
                result.cruise_time = sat_time(qc, 1'b0);
            end
            result.peak_speed  = ftf.vp;
            result.is_triangle = ftf.is_tri;
        end
    end

    assign fin_valid = vfu & vfd & vfc;
    assign take      = fin_valid & adv;
    assign hold      = prof_valid_reg & ~prof_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prof_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (hold)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            prof_valid_reg <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            prof_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            if (take)
            begin
                skid_reg <= result;
            end
        end
        else if (skid_valid_reg)
        begin
            prof_reg <= skid_reg;
        end
        else if (take)
        begin
            prof_reg <= result;
        end
    end

    assign prof_valid = prof_valid_reg;
    assign prof       = prof_reg;

endmodule

>>> tb/trapezoid_profile_planner_unit_test.sv
`timescale 1ns / 1ps

module trapezoid_profile_planner_unit_test;
    import tpp_pkg::*;

    typedef logic signed [143:0] wide_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PIPE_CYCLES = 205;

    typedef struct {
        seg_t  s;
        bit    typed;
        prof_t p;
    } seg_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  seg_valid;
    logic                  seg_ready;
    seg_t                  seg;
    logic                  prof_valid;
    logic                  prof_ready;
    prof_t                 prof;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [WORD_BITS-1:0] accel_q;
    logic [WORD_BITS-1:0] decel_q;
    logic [MIN_LEN_W-1:0] min_len_q;

    prof_t profile_q[$];
    int    mismatches;
    int    profiles_seen;
    int    segs_sent;
    bit    quiet;
    bit    hold_rx;

    trapezoid_profile_planner_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg),
        .prof_valid (prof_valid),
        .prof_ready (prof_ready),
        .prof       (prof),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [WORD_BITS-1:0] clamp_time(wide_t x);
        wide_t hi;
        wide_t lo;
        hi = 144'sd2147483647;
        lo = -144'sd2147483648;
        if (x > hi)
            return 32'h7fffffff;
        if (x < lo)
            return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic wide_t floor_root(wide_t x);
        wide_t r;
        wide_t c;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (wide_t'(1) <<< b);
            if (c * c <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic prof_t plan_profile(seg_t s);
        prof_t p;
        wide_t len, ve, vx, vm, a, d, ve2, vx2, vm2, dist_up, dist_dn;
        wide_t num, d1, vp2, vp, tc, tu, td, dc;
        p = '0;
        if (s.seg_length < WORD_BITS'(min_len_q))
        begin
            p.is_degenerate = 1'b1;
            return p;
        end
        len = s.seg_length;
        ve = s.start_speed;
        vx = s.end_speed;
        vm = s.speed_cap;
        a = (accel_q == 0) ? 1 : accel_q;
        d = (decel_q == 0) ? 1 : decel_q;
        ve2 = ve * ve;
        vx2 = vx * vx;
        vm2 = vm * vm;
        dist_up = (vm2 - ve2) / (2 * a);
        dist_dn = (vm2 - vx2) / (2 * d);
        if (len < dist_up + dist_dn)
        begin
            num = vx2 - ve2 + 2 * d * len;
            d1 = num / (2 * (a + d));
            vp2 = ve2 + 2 * a * d1;
            vp = (vp2 < 0) ? 0 : floor_root(vp2);
            if (vp > 144'sd4294967295)
                vp = 144'sd4294967295;
            tc = 0;
            p.is_triangle = 1'b1;
        end
        else
        begin
            dc = len - dist_up - dist_dn;
            vp = vm;
            if (vm == 0)
                tc = (dc == 0) ? 0 : 144'sd4294967296;
            else
                tc = (dc <<< FRAC_BITS) / vm;
        end
        tu = ((vp - ve) <<< FRAC_BITS) / a;
        td = ((vp - vx) <<< FRAC_BITS) / d;
        p.ramp_up_time = clamp_time(tu);
        p.cruise_time = clamp_time(tc);
        p.ramp_down_time = clamp_time(td);
        p.peak_speed = vp[31:0];
        return p;
    endfunction

    // Mix of corner values, small values and full-range values per field.
    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return $urandom_range(0, 255);
            4: return $urandom_range(0, 1 << 20);
            5: return $urandom_range(1 << 20, 1 << 26);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ACCEL:   accel_q = val;
            CFG_DECEL:   decel_q = val;
            CFG_MIN_LEN: min_len_q = val[MIN_LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_seg(seg_t s, bit typed, prof_t p);
        seg_valid <= 1'b1;
        seg <= s;
        @(posedge clk);
        while (!seg_ready)
            @(posedge clk);
        profile_q.insert(profile_q.size(), typed ? p : plan_profile(s));
        segs_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        @(posedge clk);
        while (profile_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 10)
            @(posedge clk);
    endtask

    task automatic random_run(int n, bit squeeze);
        seg_t s;
        for (int i = 0; i < n; i++)
        begin
            s.seg_length = pick_word();
            s.start_speed = pick_word();
            s.end_speed = pick_word();
            s.speed_cap = pick_word();
            if (squeeze && i == 10)
                hold_rx = 1'b1;
            if (i == n / 2)
            begin
                // Let the pipeline run dry with the sender paused.
                seg_valid <= 1'b0;
                @(posedge clk);
                while (profile_q.size() != 0)
                    @(posedge clk);
            end
            send_seg(s, 1'b0, '0);
        end
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        prof_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                prof_ready <= 1'b0;
                repeat (400)
                    @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                prof_ready <= 1'b0;
                repeat ($urandom_range(1, 4))
                    @(posedge clk);
            end
            else
            begin
                prof_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && prof_valid && prof_ready)
        begin
            profiles_seen++;
            if (profile_q.size() == 0)
            begin
                $display("%0t: profile beat with none expected, actual %p", $time, prof);
                mismatches++;
            end
            else
            begin
                prof_t e;
                e = profile_q.pop_front();
                if (prof.ramp_up_time !== e.ramp_up_time)
                begin
                    $display("%0t: ramp_up_time expected %0d actual %0d",
                             $time, e.ramp_up_time, prof.ramp_up_time);
                    mismatches++;
                end
                if (prof.cruise_time !== e.cruise_time)
                begin
                    $display("%0t: cruise_time expected %0d actual %0d",
                             $time, e.cruise_time, prof.cruise_time);
                    mismatches++;
                end
                if (prof.ramp_down_time !== e.ramp_down_time)
                begin
                    $display("%0t: ramp_down_time expected %0d actual %0d",
                             $time, e.ramp_down_time, prof.ramp_down_time);
                    mismatches++;
                end
                if (prof.peak_speed !== e.peak_speed)
                begin
                    $display("%0t: peak_speed expected %0d actual %0d",
                             $time, e.peak_speed, prof.peak_speed);
                    mismatches++;
                end
                if (prof.is_triangle !== e.is_triangle)
                begin
                    $display("%0t: is_triangle expected %b actual %b",
                             $time, e.is_triangle, prof.is_triangle);
                    mismatches++;
                end
                if (prof.is_degenerate !== e.is_degenerate)
                begin
                    $display("%0t: is_degenerate expected %b actual %b",
                             $time, e.is_degenerate, prof.is_degenerate);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d profiles outstanding", profile_q.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        seg_row_t rows[$];
        prof_t degen;
        prof_t stopped;
        prof_t zero_p;
        degen = '0;
        degen.is_degenerate = 1'b1;
        stopped = '0;
        stopped.cruise_time = 32'h7fffffff;
        zero_p = '0;
        mismatches = 0;
        profiles_seen = 0;
        segs_sent = 0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        rst_n = 1'b0;
        seg_valid = 1'b0;
        seg = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ACCEL;
        cfg_data = '0;
        accel_q = ACCEL_RST;
        decel_q = DECEL_RST;
        min_len_q = MIN_LEN_RST;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments at the reset rates.
        rows.insert(rows.size(), '{'{32'd0, 32'd100, 32'd100, 32'd500}, 1'b1, degen});
        rows.insert(rows.size(), '{'{32'd0, '1, '1, '1}, 1'b1, degen});
        rows.insert(rows.size(), '{'{32'd1, 32'd0, 32'd0, 32'd0}, 1'b1, stopped});
        rows.insert(rows.size(), '{'{'1, 32'd0, 32'd0, 32'd0}, 1'b1, stopped});
        rows.insert(rows.size(), '{'{'1, '1, '1, '1}, 1'b0, zero_p});
        rows.insert(rows.size(), '{'{32'd1, '1, '1, '1}, 1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'h0064_0000, 32'h000a_0000, 32'h0005_0000, 32'h0032_0000},
                      1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000},
                      1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'h0100_0000, 32'h0050_0000, 32'h0010_0000, 32'h0020_0000},
                      1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'h0000_0010, 32'hffff_0000, 32'h0000_0000, 32'hffff_ffff},
                      1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'h1000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001},
                      1'b0, zero_p});
        rows.insert(rows.size(),
                    '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
                      1'b0, zero_p});
        foreach (rows[i])
            send_seg(rows[i].s, rows[i].typed, rows[i].p);
        drain();

        // Zero rates act as the smallest rate; the spare index is ignored.
        write_reg(CFG_ACCEL, 32'd0);
        write_reg(CFG_DECEL, 32'd0);
        write_reg(CFG_MIN_LEN, 32'd0);
        write_reg(CFG_SPARE, 32'hdead_beef);
        send_seg('{32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, zero_p);
        send_seg('{32'h0000_0100, 32'h0000_1000, 32'h0000_0000, 32'h0001_0000}, 1'b0, zero_p);
        send_seg('{'1, '1, 32'd0, '1}, 1'b0, zero_p);
        random_run(100, 1'b1);
        drain();

        write_reg(CFG_ACCEL, 32'hffff_ffff);
        write_reg(CFG_DECEL, 32'd1);
        write_reg(CFG_MIN_LEN, 32'h0000_ffff);
        random_run(130, 1'b0);
        drain();

        write_reg(CFG_ACCEL, 32'd1);
        write_reg(CFG_DECEL, 32'hffff_ffff);
        write_reg(CFG_MIN_LEN, 32'd16);
        random_run(130, 1'b0);
        drain();

        write_reg(CFG_ACCEL, $urandom_range(1, 1 << 28));
        write_reg(CFG_DECEL, $urandom_range(1, 1 << 28));
        write_reg(CFG_MIN_LEN, $urandom_range(0, 65535));
        random_run(130, 1'b0);
        drain();

        write_reg(CFG_ACCEL, ACCEL_RST);
        write_reg(CFG_DECEL, $urandom());
        write_reg(CFG_MIN_LEN, MIN_LEN_RST);
        quiet = 1'b1;
        random_run(140, 1'b0);
        drain();

        $display("Sent %0d segments and checked %0d profiles over six rate and length settings,",
                 segs_sent, profiles_seen);
        $display("including zero and full-scale rates and a long receiver stall.");
        if (mismatches == 0 && profile_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
